[rtl/rgbm_pkg.sv]
// ----------------------------------------------------------------------------
// rgbm_pkg
// Shared constants and types of the per-channel median block.
// ----------------------------------------------------------------------------
package rgbm_pkg;

  localparam int MaxSamples = 64;
  localparam int SampleW    = 8;
  localparam int UsedW      = 7;
  localparam int CntW       = $clog2(MaxSamples + 1);
  localparam int DrainW     = $clog2(MaxSamples / 2 + 1);
  localparam int InDataW    = 3 * SampleW;
  localparam int OutDataW   = ((3 * SampleW + UsedW + 1 + 7) / 8) * 8;

  // per-cycle command shared by every cell of the chain
  typedef struct packed {
    logic ins;    // insert the broadcast sample in sorted order
    logic shift;  // move every entry one cell towards the head
    logic clr;    // empty the whole chain
  } cell_ctrl_t;

endpackage

[rtl/rgb_channel_median.sv]
// ----------------------------------------------------------------------------
// rgb_channel_median
// Per-channel median of one pixel's RGB sample set, using one insertion
// sorting chain per channel.
// ----------------------------------------------------------------------------
//  channel   dir   tdata                                   side band
//  s_axis    in    red, green, blue                        tuser has_sample,
//                                                          tlast last_in_set
//  m_axis    out   median r/g/b, samples_used, overflow    -
//
//  samples enter at one transaction per cycle while collecting; each is
//  sorted into the cell chains in the cycle it is taken
//  after the last transaction of a set the chains shift out count/2 entries,
//  then the heads are registered once the output register is free
//  s_axis_tready_o is low during the shift-out and until that load; the
//  result waits in the output register while the next set is collected
//  reset empties the chains at once via the per-cell valid flags
// ----------------------------------------------------------------------------
module rgb_channel_median import rgbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // red_sample, green_sample, blue_sample
  input  logic                s_axis_tuser_i,   // has_sample
  input  logic                s_axis_tlast_i,   // last_in_set
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // median_red, median_green,
                                                // median_blue, samples_used, overflow
);

  typedef enum logic [1:0] {
    StCollect = 2'b01,
    StDrain   = 2'b10
  } state_e;

  state_e             state_d, state_q;
  logic [CntW-1:0]    count_d, count_q;
  logic [DrainW-1:0]  drain_d, drain_q;
  logic               ovf_d, ovf_q;
  logic               out_vld_d, out_vld_q;
  logic [SampleW-1:0] med_r_q, med_g_q, med_b_q;
  logic [UsedW-1:0]   used_q;
  logic               out_ovf_q;

  logic               in_acc, full, load;
  cell_ctrl_t         ctrl;
  logic               head_vld_r, head_vld_g, head_vld_b;
  logic [SampleW-1:0] head_r, head_g, head_b;
  logic [CntW-1:0]    count_new;

  assign s_axis_tready_o = (state_q == StCollect);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CntW'(MaxSamples));
  assign load            = (state_q == StDrain) && (drain_q == '0)
                           && (!out_vld_q || m_axis_tready_i);

  assign ctrl.ins   = in_acc && s_axis_tuser_i && !full;
  assign ctrl.shift = (state_q == StDrain) && (drain_q != '0);
  assign ctrl.clr   = load;

  assign count_new = count_q + CntW'(ctrl.ins);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    drain_d   = drain_q;
    ovf_d     = ovf_q;
    out_vld_d = out_vld_q;
    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      StCollect: begin
        if (in_acc) begin
          count_d = count_new;
          if (s_axis_tuser_i && full) begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            drain_d = DrainW'(count_new >> 1);
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (drain_q != '0) begin
          drain_d = drain_q - DrainW'(1);
        end else if (load) begin
          out_vld_d = 1'b1;
          count_d   = '0;
          ovf_d     = 1'b0;
          state_d   = StCollect;
        end
      end
      default: begin
        state_d = StCollect;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StCollect;
      count_q   <= '0;
      drain_q   <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      drain_q   <= drain_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
    end
  end

  // an empty set reads as zero on every channel
  always_ff @(posedge clk_i) begin
    if (load) begin
      med_r_q   <= (count_q == '0) ? '0 : head_r;
      med_g_q   <= (count_q == '0) ? '0 : head_g;
      med_b_q   <= (count_q == '0) ? '0 : head_b;
      used_q    <= UsedW'(count_q);
      out_ovf_q <= ovf_q;
    end
  end

  rgbm_chain u_chain_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .sample_i   (s_axis_tdata_i[SampleW-1:0]),
    .head_vld_o (head_vld_r),
    .head_val_o (head_r)
  );

  rgbm_chain u_chain_g (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .sample_i   (s_axis_tdata_i[2*SampleW-1:SampleW]),
    .head_vld_o (head_vld_g),
    .head_val_o (head_g)
  );

  rgbm_chain u_chain_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .sample_i   (s_axis_tdata_i[3*SampleW-1:2*SampleW]),
    .head_vld_o (head_vld_b),
    .head_val_o (head_b)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OutDataW'({out_ovf_q, used_q, med_b_q, med_g_q, med_r_q});

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxSamples))
    else $error("sample count above store size");

  a_ovf_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flagged with room left in store");

  a_drain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> (CntW'(drain_q) <= (count_q >> 1)))
    else $error("shift-out count beyond half the set");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (count_q != '0)) |-> (head_vld_r && head_vld_g && head_vld_b))
    else $error("median taken from an empty cell");

  a_load_sets_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (m_axis_tvalid_o && (state_q == StCollect) && (count_q == '0)))
    else $error("result not presented after shift-out");
`endif

endmodule

[rtl/rgbm_cell.sv]
// ----------------------------------------------------------------------------
// rgbm_cell
// One sorting cell: holds one sample of one channel and trades it with its
// neighbours on insert and on shift-out.
// ----------------------------------------------------------------------------
module rgbm_cell import rgbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic               prev_gt_i,
  input  logic               prev_vld_i,
  input  logic [SampleW-1:0] prev_val_i,
  input  logic               next_vld_i,
  input  logic [SampleW-1:0] next_val_i,
  output logic               gt_o,
  output logic               vld_o,
  output logic [SampleW-1:0] val_o
);

  logic               vld_d, vld_q;
  logic [SampleW-1:0] val_d, val_q;

  // empty cells count as larger, so the chain stays sorted with holes at the tail
  assign gt_o  = !vld_q || (val_q > sample_i);
  assign vld_o = vld_q;
  assign val_o = val_q;

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    if (ctrl_i.clr) begin
      vld_d = 1'b0;
    end else if (ctrl_i.shift) begin
      vld_d = next_vld_i;
      val_d = next_val_i;
    end else if (ctrl_i.ins && gt_o) begin
      if (prev_gt_i) begin
        vld_d = prev_vld_i;
        val_d = prev_val_i;
      end else begin
        vld_d = 1'b1;
        val_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

[rtl/rgbm_chain.sv]
// ----------------------------------------------------------------------------
// rgbm_chain
// Row of sorting cells for one channel, ascending from the head cell.
// ----------------------------------------------------------------------------
module rgbm_chain import rgbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic [SampleW-1:0] sample_i,
  output logic               head_vld_o,
  output logic [SampleW-1:0] head_val_o
);

  logic               gt  [MaxSamples];
  logic               vld [MaxSamples];
  logic [SampleW-1:0] val [MaxSamples];

  for (genvar i = 0; i < MaxSamples; i++) begin : g_cell
    logic               prev_gt, prev_vld, next_vld;
    logic [SampleW-1:0] prev_val, next_val;

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_vld = 1'b0;
      assign prev_val = '0;
    end else begin : g_body
      assign prev_gt  = gt[i-1];
      assign prev_vld = vld[i-1];
      assign prev_val = val[i-1];
    end

    if (i == MaxSamples - 1) begin : g_tail
      assign next_vld = 1'b0;
      assign next_val = '0;
    end else begin : g_inner
      assign next_vld = vld[i+1];
      assign next_val = val[i+1];
    end

    rgbm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .sample_i   (sample_i),
      .prev_gt_i  (prev_gt),
      .prev_vld_i (prev_vld),
      .prev_val_i (prev_val),
      .next_vld_i (next_vld),
      .next_val_i (next_val),
      .gt_o       (gt[i]),
      .vld_o      (vld[i]),
      .val_o      (val[i])
    );
  end

  assign head_vld_o = vld[0];
  assign head_val_o = val[0];

endmodule

[sim/rgb_channel_median_tb.sv]
// ----------------------------------------------------------------------------
// rgb_channel_median_tb
// Self-checking bench for the per-channel median block. A negedge driver
// feeds sample transactions from a queue of pending items, and a posedge
// monitor tracks every accepted sample in its own copy of the sample sets.
// At each end of set it works out the upper median of every channel and
// checks the result stream against it field by field. A short directed
// opening is followed by random sets, empty sets, marker items and full or
// over-full stores, under three back-pressure profiles.
// ----------------------------------------------------------------------------
module rgb_channel_median_tb;
  import rgbm_pkg::*;

  localparam int PhaseItems = 300;
  localparam int CycleLimit = 600000;

  typedef struct packed {
    logic [SampleW-1:0] red;
    logic [SampleW-1:0] green;
    logic [SampleW-1:0] blue;
    logic               has_sample;
    logic               last_in_set;
  } sample_item_t;

  typedef struct packed {
    logic [SampleW-1:0] red;
    logic [SampleW-1:0] green;
    logic [SampleW-1:0] blue;
    logic [UsedW-1:0]   used;
    logic               overflow;
  } median_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;    // red, green, blue
  logic                s_axis_tuser = 1'b0;  // has_sample
  logic                s_axis_tlast = 1'b0;  // last_in_set
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // red, green, blue, samples_used, overflow

  sample_item_t pending_q[$];
  median_t      median_q[$];

  // predictor state: samples kept in the current set, per channel
  logic [SampleW-1:0] kept [3][MaxSamples];
  int                 kept_cnt = 0;
  logic               dropped = 1'b0;

  logic s_acc = 1'b0;
  int   src_idle_pct = 0;
  int   dst_idle_pct = 0;
  int   errors = 0;
  int   cycles = 0;
  int   items_queued = 0;
  int   sets_queued = 0;
  int   results_seen = 0;
  int   full_sets = 0;
  int   empty_sets = 0;

  rgb_channel_median DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d items pending, %0d results outstanding",
               $time, pending_q.size(), median_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // rank count/2 of the kept entries of one channel, ascending
  function automatic logic [SampleW-1:0] upper_median(input int ch);
    logic [SampleW-1:0] srt [MaxSamples];
    logic [SampleW-1:0] v;
    int                 i;
    int                 j;
    for (i = 0; i < kept_cnt; i++) begin
      v = kept[ch][i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    return srt[kept_cnt / 2];
  endfunction

  task automatic absorb_sample(input sample_item_t it);
    median_t res;
    if (it.has_sample) begin
      if (kept_cnt < MaxSamples) begin
        kept[0][kept_cnt] = it.red;
        kept[1][kept_cnt] = it.green;
        kept[2][kept_cnt] = it.blue;
        kept_cnt++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (it.last_in_set) begin
      if (kept_cnt == 0) begin
        res.red   = '0;
        res.green = '0;
        res.blue  = '0;
      end else begin
        res.red   = upper_median(0);
        res.green = upper_median(1);
        res.blue  = upper_median(2);
      end
      res.used     = UsedW'(kept_cnt);
      res.overflow = dropped;
      median_q = {median_q, res};
      kept_cnt = 0;
      dropped  = 1'b0;
    end
  endtask

  task automatic check_median(input logic [OutDataW-1:0] d);
    median_t got;
    median_t want;
    got.red      = d[SampleW-1:0];
    got.green    = d[2*SampleW-1:SampleW];
    got.blue     = d[3*SampleW-1:2*SampleW];
    got.used     = d[3*SampleW+UsedW-1:3*SampleW];
    got.overflow = d[3*SampleW+UsedW];
    if (median_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, actual r=%0d g=%0d b=%0d used=%0d ovf=%0b",
               $time, got.red, got.green, got.blue, got.used, got.overflow);
    end else begin
      want = median_q.pop_front();
      results_seen++;
      if (got.red !== want.red) begin
        errors++;
        $display("%0t: median_red expected %0d actual %0d", $time, want.red, got.red);
      end
      if (got.green !== want.green) begin
        errors++;
        $display("%0t: median_green expected %0d actual %0d", $time, want.green,
                 got.green);
      end
      if (got.blue !== want.blue) begin
        errors++;
        $display("%0t: median_blue expected %0d actual %0d", $time, want.blue, got.blue);
      end
      if (got.used !== want.used) begin
        errors++;
        $display("%0t: samples_used expected %0d actual %0d", $time, want.used,
                 got.used);
      end
      if (got.overflow !== want.overflow) begin
        errors++;
        $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                 got.overflow);
      end
    end
  endtask

  // monitor: input and output transactions at the rising edge
  always @(posedge clk_i) begin : monitor
    sample_item_t it;
    if (!rst_ni) begin
      s_acc <= 1'b0;
    end else begin
      s_acc <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        it.red         = s_axis_tdata[SampleW-1:0];
        it.green       = s_axis_tdata[2*SampleW-1:SampleW];
        it.blue        = s_axis_tdata[3*SampleW-1:2*SampleW];
        it.has_sample  = s_axis_tuser;
        it.last_in_set = s_axis_tlast;
        absorb_sample(it);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_median(m_axis_tdata);
      end
    end
  end

  // driver: holds the current transaction until taken, then may idle
  always @(negedge clk_i) begin : driver
    sample_item_t it;
    if (rst_ni && (!s_axis_tvalid || s_acc)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        it = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.blue, it.green, it.red};
        s_axis_tuser  <= it.has_sample;
        s_axis_tlast  <= it.last_in_set;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // mostly full-range values, some extremes and a narrow band for ties
  function automatic logic [SampleW-1:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return SampleW'($urandom_range(3));
      default: return SampleW'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic [SampleW-1:0] r, input logic [SampleW-1:0] g,
                            input logic [SampleW-1:0] b, input logic has,
                            input logic last);
    sample_item_t it;
    it.red         = r;
    it.green       = g;
    it.blue        = b;
    it.has_sample  = has;
    it.last_in_set = last;
    pending_q = {pending_q, it};
    items_queued++;
    if (last) sets_queued++;
  endtask

  // one sample set with random content, stray markers and either a sample
  // or a bare marker closing it
  task automatic queue_set(input int n);
    int i;
    bit marker_end;
    marker_end = (n == 0) || ($urandom_range(4) == 0);
    if (n == 0) empty_sets++;
    if (n > MaxSamples) full_sets++;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        queue_item(pick_value(), pick_value(), pick_value(), 1'b0, 1'b0);
      end
      queue_item(pick_value(), pick_value(), pick_value(), 1'b1,
                 !marker_end && (i == n - 1));
    end
    if (marker_end) begin
      queue_item(pick_value(), pick_value(), pick_value(), 1'b0, 1'b1);
    end
  endtask

  function automatic int pick_set_size();
    int p;
    p = $urandom_range(99);
    if (p < 8) return 0;
    if (p < 70) return $urandom_range(8, 1);
    if (p < 85) return $urandom_range(40, 9);
    if (p < 93) return $urandom_range(MaxSamples, MaxSamples - 2);
    return $urandom_range(MaxSamples + 8, MaxSamples + 1);
  endfunction

  initial begin : stimulus
    int ph;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 23;
          dst_idle_pct = 81;
        end
        1: begin
          src_idle_pct = 81;
          dst_idle_pct = 23;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase

      if (ph == 0) begin
        // single samples at both extremes
        queue_item(8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
        queue_item(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
        // even count takes the upper of the two middle values
        queue_item(8'd10, 8'd200, 8'd0, 1'b1, 1'b0);
        queue_item(8'd20, 8'd100, 8'd255, 1'b1, 1'b1);
        // empty set
        queue_item(8'h5a, 8'ha5, 8'hff, 1'b0, 1'b1);
        empty_sets++;
        // markers around one sample, closed by a bare marker
        queue_item(8'hff, 8'hff, 8'hff, 1'b0, 1'b0);
        queue_item(8'h55, 8'haa, 8'h0f, 1'b1, 1'b0);
        queue_item(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        queue_item(8'hf0, 8'h0f, 8'h33, 1'b0, 1'b1);
        // odd count, each channel in a different order
        queue_item(8'd3, 8'd1, 8'd2, 1'b1, 1'b0);
        queue_item(8'd1, 8'd2, 8'd3, 1'b1, 1'b0);
        queue_item(8'd2, 8'd3, 8'd1, 1'b1, 1'b1);
        // ties and extremes in one set
        queue_item(8'd7, 8'd7, 8'd0, 1'b1, 1'b0);
        queue_item(8'd7, 8'd0, 8'd255, 1'b1, 1'b0);
        queue_item(8'd0, 8'd7, 8'd255, 1'b1, 1'b0);
        queue_item(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
      end else if (ph == 1) begin
        queue_set(MaxSamples);
      end else begin
        queue_set(MaxSamples + 2);
      end

      while (items_queued < (ph + 1) * PhaseItems) queue_set(pick_set_size());

      // sender holds off until every result of this phase is back
      while (pending_q.size() != 0 || s_axis_tvalid || median_q.size() != 0) begin
        @(posedge clk_i);
      end
    end

    repeat (4 * MaxSamples) @(posedge clk_i);

    $display("%0d items in %0d sets, %0d results checked", items_queued, sets_queued,
             results_seen);
    $display("%0d over-full sets, %0d empty sets, three back-pressure profiles",
             full_sets, empty_sets);
    if (errors == 0 && median_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, median_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rgbm_pkg.sv
rtl/rgbm_cell.sv
rtl/rgbm_chain.sv
rtl/rgb_channel_median.sv
sim/rgb_channel_median_tb.sv
